// ===== hdl/ipg_pkg.sv =====
// ----------------------------------------------------------------------------
// Integer partition generator package
// Shared widths, command codes, the command beat type and the engine states.
// ----------------------------------------------------------------------------
package ipg_pkg;

  localparam int unsigned MAX_TOTAL = 16;
  localparam int unsigned PART_W    = 5;
  localparam int unsigned IDX_W     = $clog2(MAX_TOTAL);
  localparam int unsigned CNT_W     = $clog2(MAX_TOTAL + 1);

  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_ADVANCE,
    CMD_EXHAUST
  } cmd_e;

  typedef struct packed {
    cmd_e              op;
    logic [PART_W-1:0] total;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_SCAN,
    ST_EMIT
  } back_state_e;

endpackage

// ===== hdl/integer_partition_generator.sv =====
// ----------------------------------------------------------------------------
// Integer partition generator
// Enumerates the partitions of a total in lexicographic order, one part per
// result beat.
// ----------------------------------------------------------------------------
// A start command with total n writes n ones into the part store, one per
// cycle, and then streams the n parts. An advance scans the stored parts from
// the end, one read per cycle, writes the grown part and the refilled ones one
// per cycle, and then streams the new partition one part per cycle. Commands
// enter a two-entry queue, and busy is high only while that queue is full.
// Result beats cannot be held off: each stands on the result ports for one
// cycle with result_valid_o high.
module integer_partition_generator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       operation_i,
  input  logic [ipg_pkg::PART_W-1:0] total_i,
  output logic                       result_valid_o,
  output logic [ipg_pkg::PART_W-1:0] part_o,
  output logic                       last_part_o,
  output logic                       exhausted_o
);

  logic          full;
  logic          push;
  logic          pop;
  logic          cmd_valid;
  ipg_pkg::cmd_t cmd_in;
  ipg_pkg::cmd_t cmd_out;

  ipg_front u_front (
    .start_i    (start),
    .operation_i(operation_i),
    .total_i    (total_i),
    .full_i     (full),
    .busy_o     (busy),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  ipg_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_in),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(cmd_valid),
    .cmd_o  (cmd_out)
  );

  ipg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd_out),
    .cmd_pop_o     (pop),
    .result_valid_o(result_valid_o),
    .part_o        (part_o),
    .last_part_o   (last_part_o),
    .exhausted_o   (exhausted_o)
  );

endmodule

// ===== hdl/ipg_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ipg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ipg_front.sv =====
// ----------------------------------------------------------------------------
// Integer partition generator front end
// Accepts command beats, saturates the total and classifies each command.
// ----------------------------------------------------------------------------
module ipg_front (
  input  logic                       start_i,
  input  logic                       operation_i,
  input  logic [ipg_pkg::PART_W-1:0] total_i,
  input  logic                       full_i,
  output logic                       busy_o,
  output logic                       push_o,
  output ipg_pkg::cmd_t              cmd_o
);

  localparam logic [ipg_pkg::PART_W-1:0] TotalMax = ipg_pkg::PART_W'(ipg_pkg::MAX_TOTAL);

  assign busy_o = full_i;
  assign push_o = start_i && !full_i;

  always_comb begin
    cmd_o.total = (total_i > TotalMax) ? TotalMax : total_i;
    if (operation_i == ipg_pkg::OP_ADVANCE) begin
      cmd_o.op = ipg_pkg::CMD_ADVANCE;
    end else if (total_i == '0) begin
      cmd_o.op = ipg_pkg::CMD_EXHAUST;
    end else begin
      cmd_o.op = ipg_pkg::CMD_START;
    end
  end

endmodule

// ===== hdl/ipg_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// Integer partition generator command queue
// Two-entry queue that decouples the front end from the engine.
// ----------------------------------------------------------------------------
module ipg_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ipg_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ipg_pkg::cmd_t cmd_o
);

  ipg_pkg::cmd_t entry_q [2];
  logic          wptr_q, wptr_d;
  logic          rptr_q, rptr_d;
  logic [1:0]    count_q, count_d;
  logic          do_push, do_pop;

  assign do_push = push_i && (count_q != 2'd2);
  assign do_pop  = pop_i && (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = entry_q[rptr_q];

  always_comb begin
    wptr_d  = do_push ? !wptr_q : wptr_q;
    rptr_d  = do_pop ? !rptr_q : rptr_q;
    count_d = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= cmd_i;
    end
  end

endmodule

// ===== hdl/ipg_back.sv =====
// ----------------------------------------------------------------------------
// Integer partition generator engine
// Holds the current partition, steps it to its successor and streams parts.
// ----------------------------------------------------------------------------
module ipg_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  ipg_pkg::cmd_t              cmd_i,
  output logic                       cmd_pop_o,
  output logic                       result_valid_o,
  output logic [ipg_pkg::PART_W-1:0] part_o,
  output logic                       last_part_o,
  output logic                       exhausted_o
);

  localparam int unsigned IW = ipg_pkg::IDX_W;
  localparam int unsigned CW = ipg_pkg::CNT_W;
  localparam int unsigned PW = ipg_pkg::PART_W;

  ipg_pkg::back_state_e state_q, state_d;

  logic [CW-1:0] pc_q, pc_d;
  logic          active_q, active_d;
  logic [IW-1:0] ra_q, ra_d;
  logic [IW-1:0] rj_q, rj_d;
  logic          rv_q, rv_d;
  logic [PW-1:0] cand_q, cand_d;
  logic [CW-1:0] suf_q, suf_d;
  logic [CW-1:0] wa_q, wa_d;
  logic [CW-1:0] end_q, end_d;
  logic [CW-1:0] ek_q, ek_d;
  logic          pv_q, pv_d;
  logic          plast_q, plast_d;
  logic          pexh_q, pexh_d;
  logic          out_v_q;
  logic [PW-1:0] out_part_q;
  logic          out_last_q;
  logic          out_exh_q;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [PW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [PW-1:0] ram_rdata;

  logic          arrive;
  logic [CW-1:0] jx;
  logic          first_arr;
  logic          has_cand;
  logic          hit_hi;
  logic          hit_lo;
  logic          found;
  logic [IW-1:0] found_idx;
  logic [PW-1:0] found_val;
  logic [CW-1:0] found_suf;
  logic [CW-1:0] suf_acc;
  logic          adv_ok;

  ipg_ram #(
    .WIDTH(PW),
    .DEPTH(ipg_pkg::MAX_TOTAL)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Scan runs from the last part downward; a hit is the rightmost non-final
  // part that is smaller than its left neighbor, or the first part.
  always_comb begin
    arrive    = (state_q == ipg_pkg::ST_SCAN) && rv_q;
    jx        = {{(CW-IW){1'b0}}, rj_q};
    first_arr = ((jx + CW'(1)) == pc_q);
    has_cand  = ((jx + CW'(3)) <= pc_q);
    suf_acc   = suf_q + (has_cand ? CW'(cand_q) : '0);
    hit_hi    = arrive && !first_arr && has_cand && (cand_q < ram_rdata);
    hit_lo    = arrive && !first_arr && !hit_hi && (rj_q == '0);
    found     = hit_hi || hit_lo;
    found_idx = hit_hi ? (rj_q + IW'(1)) : '0;
    found_val = hit_hi ? cand_q : ram_rdata;
    found_suf = hit_hi ? suf_q : suf_acc;
    adv_ok    = active_q && (pc_q >= CW'(2));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ipg_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.op == ipg_pkg::CMD_START) begin
            state_d = ipg_pkg::ST_FILL;
          end else if (cmd_i.op == ipg_pkg::CMD_ADVANCE && adv_ok) begin
            state_d = ipg_pkg::ST_SCAN;
          end
        end
      end
      ipg_pkg::ST_FILL: begin
        if (wa_q >= end_q) begin
          state_d = ipg_pkg::ST_EMIT;
        end
      end
      ipg_pkg::ST_SCAN: begin
        if (found) begin
          state_d = ipg_pkg::ST_FILL;
        end
      end
      ipg_pkg::ST_EMIT: begin
        if ((ek_q + CW'(1)) >= pc_q) begin
          state_d = ipg_pkg::ST_IDLE;
        end
      end
      default: state_d = ipg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pc_d      = pc_q;
    active_d  = active_q;
    ra_d      = ra_q;
    rj_d      = rj_q;
    rv_d      = 1'b0;
    cand_d    = cand_q;
    suf_d     = suf_q;
    wa_d      = wa_q;
    end_d     = end_q;
    ek_d      = ek_q;
    pv_d      = 1'b0;
    plast_d   = 1'b0;
    pexh_d    = 1'b0;
    cmd_pop_o = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = wa_q[IW-1:0];
    ram_wdata = PW'(1);
    ram_raddr = ra_q;
    unique case (state_q)
      ipg_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            ipg_pkg::CMD_START: begin
              active_d = 1'b1;
              wa_d     = '0;
              end_d    = CW'(cmd_i.total);
            end
            ipg_pkg::CMD_ADVANCE: begin
              if (adv_ok) begin
                ra_d = IW'(pc_q - CW'(1));
              end else begin
                active_d = 1'b0;
                pv_d     = 1'b1;
                plast_d  = 1'b1;
                pexh_d   = 1'b1;
              end
            end
            default: begin
              active_d = 1'b0;
              pc_d     = '0;
              pv_d     = 1'b1;
              plast_d  = 1'b1;
              pexh_d   = 1'b1;
            end
          endcase
        end
      end
      ipg_pkg::ST_FILL: begin
        if (wa_q < end_q) begin
          ram_we = 1'b1;
          wa_d   = wa_q + CW'(1);
        end else begin
          pc_d = end_q;
          ek_d = '0;
        end
      end
      ipg_pkg::ST_SCAN: begin
        rv_d = 1'b1;
        rj_d = ra_q;
        if (ra_q != '0) begin
          ra_d = ra_q - IW'(1);
        end
        if (arrive) begin
          if (first_arr) begin
            suf_d = CW'(ram_rdata);
          end else begin
            suf_d  = suf_acc;
            cand_d = ram_rdata;
          end
        end
        if (found) begin
          ram_we    = 1'b1;
          ram_waddr = found_idx;
          ram_wdata = found_val + PW'(1);
          wa_d      = CW'(found_idx) + CW'(1);
          end_d     = CW'(found_idx) + found_suf;
        end
      end
      ipg_pkg::ST_EMIT: begin
        ram_raddr = ek_q[IW-1:0];
        pv_d      = 1'b1;
        plast_d   = ((ek_q + CW'(1)) == pc_q);
        ek_d      = ek_q + CW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ipg_pkg::ST_IDLE;
      pc_q     <= '0;
      active_q <= 1'b0;
      rv_q     <= 1'b0;
      pv_q     <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      pc_q     <= pc_d;
      active_q <= active_d;
      rv_q     <= rv_d;
      pv_q     <= pv_d;
      out_v_q  <= pv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q       <= ra_d;
    rj_q       <= rj_d;
    cand_q     <= cand_d;
    suf_q      <= suf_d;
    wa_q       <= wa_d;
    end_q      <= end_d;
    ek_q       <= ek_d;
    plast_q    <= plast_d;
    pexh_q     <= pexh_d;
    out_part_q <= pexh_q ? '0 : ram_rdata;
    out_last_q <= plast_q;
    out_exh_q  <= pexh_q;
  end

  assign result_valid_o = out_v_q;
  assign part_o         = out_part_q;
  assign last_part_o    = out_last_q;
  assign exhausted_o    = out_exh_q;

`ifndef SYNTHESIS
  a_exh_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_exh_q |-> out_last_q && (out_part_q == '0))
    else $error("exhausted beat must be a zero final part");

  a_part_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !out_exh_q |-> (out_part_q != '0))
    else $error("emitted part is zero");

  a_scan_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ipg_pkg::ST_SCAN |-> active_q && (pc_q >= CW'(2)))
    else $error("scan without a loaded partition of two or more parts");

  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ipg_pkg::ST_EMIT |-> (ek_q < pc_q))
    else $error("emit index past part count");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ipg_pkg::ST_FILL |->
      (wa_q <= end_q) && (end_q <= CW'(ipg_pkg::MAX_TOTAL)))
    else $error("refill range out of bounds");
`endif

endmodule

// ===== sim/integer_partition_generator_tb.sv =====
// ----------------------------------------------------------------------------
// Integer partition generator testbench
// Sends start and advance commands with random gaps, predicts every partition
// and exhausted beat from a shadow copy of the part store, and checks each
// result beat in order against that prediction.
// ----------------------------------------------------------------------------
module integer_partition_generator_tb;

  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 220;

  typedef struct packed {
    logic [ipg_pkg::PART_W-1:0] part;
    logic                       last_part;
    logic                       exhausted;
  } part_beat_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic                       operation_i;
  logic [ipg_pkg::PART_W-1:0] total_i;
  logic                       result_valid_o;
  logic [ipg_pkg::PART_W-1:0] part_o;
  logic                       last_part_o;
  logic                       exhausted_o;

  logic [ipg_pkg::PART_W-1:0] shadow_parts [ipg_pkg::MAX_TOTAL];
  int unsigned                shadow_len;
  int unsigned                shadow_sum;
  bit                         shadow_live;

  part_beat_t  expected_parts[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          no_idle;

  integer_partition_generator uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .total_i        (total_i),
    .result_valid_o (result_valid_o),
    .part_o         (part_o),
    .last_part_o    (last_part_o),
    .exhausted_o    (exhausted_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void push_exhausted();
    part_beat_t b;
    b.part      = '0;
    b.last_part = 1'b1;
    b.exhausted = 1'b1;
    expected_parts.push_back(b);
  endfunction

  function automatic void push_partition();
    part_beat_t b;
    for (int unsigned k = 0; k < shadow_len && k < ipg_pkg::MAX_TOTAL; k++) begin
      b.part      = shadow_parts[k];
      b.last_part = (k + 1 == shadow_len);
      b.exhausted = 1'b0;
      expected_parts.push_back(b);
    end
  endfunction

  function automatic void predict_partition_step(
    input logic                       op,
    input logic [ipg_pkg::PART_W-1:0] tot
  );
    int unsigned n;
    int unsigned grow;
    int unsigned prefix;
    int unsigned rest;
    n = 32'(tot);
    if (op == ipg_pkg::OP_START) begin
      if (n == 0) begin
        shadow_live = 1'b0;
        shadow_len  = 0;
        shadow_sum  = 0;
        push_exhausted();
        return;
      end
      if (n > ipg_pkg::MAX_TOTAL) n = ipg_pkg::MAX_TOTAL;
      shadow_sum = n;
      for (int unsigned k = 0; k < n; k++) shadow_parts[k] = ipg_pkg::PART_W'(1);
      shadow_len  = n;
      shadow_live = 1'b1;
      push_partition();
      return;
    end
    if (!shadow_live || shadow_len < 2 || shadow_len > ipg_pkg::MAX_TOTAL) begin
      shadow_live = 1'b0;
      push_exhausted();
      return;
    end
    grow = shadow_len - 2;
    while (grow != 0 && shadow_parts[grow] >= shadow_parts[grow-1]) grow--;
    shadow_parts[grow] = shadow_parts[grow] + ipg_pkg::PART_W'(1);
    prefix = 0;
    for (int unsigned k = 0; k <= grow; k++) prefix += 32'(shadow_parts[k]);
    rest = (shadow_sum >= prefix) ? shadow_sum - prefix : 0;
    if (grow + 1 + rest > ipg_pkg::MAX_TOTAL) rest = ipg_pkg::MAX_TOTAL - (grow + 1);
    for (int unsigned k = 0; k < rest; k++) shadow_parts[grow + 1 + k] = ipg_pkg::PART_W'(1);
    shadow_len = grow + 1 + rest;
    push_partition();
  endfunction

  task automatic issue_command(input logic op, input logic [ipg_pkg::PART_W-1:0] tot);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    repeat (gap) begin
      start       = 1'b0;
      operation_i = 1'($urandom_range(0, 1));
      total_i     = ipg_pkg::PART_W'($urandom_range(0, 31));
      @(negedge clk_i);
    end
    start       = 1'b1;
    operation_i = op;
    total_i     = tot;
    do @(posedge clk_i); while (busy);
    predict_partition_step(op, tot);
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic wait_for_drain();
    while (expected_parts.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_idle_advance();
    issue_command(ipg_pkg::OP_ADVANCE, 5'd3);
  endtask

  task automatic test_corner_totals();
    issue_command(ipg_pkg::OP_START, 5'd1);
    issue_command(ipg_pkg::OP_ADVANCE, 5'd0);
    issue_command(ipg_pkg::OP_ADVANCE, 5'd31);
    issue_command(ipg_pkg::OP_START, 5'd0);
    issue_command(ipg_pkg::OP_ADVANCE, 5'd16);
    issue_command(ipg_pkg::OP_START, 5'd31);
    issue_command(ipg_pkg::OP_ADVANCE, 5'd0);
    issue_command(ipg_pkg::OP_ADVANCE, 5'd0);
    issue_command(ipg_pkg::OP_START, 5'd17);
    issue_command(ipg_pkg::OP_ADVANCE, 5'd0);
    issue_command(ipg_pkg::OP_START, 5'd16);
    issue_command(ipg_pkg::OP_ADVANCE, 5'd0);
  endtask

  task automatic test_full_enumeration();
    issue_command(ipg_pkg::OP_START, 5'd4);
    repeat (6) issue_command(ipg_pkg::OP_ADVANCE, 5'd0);
  endtask

  task automatic test_drain_pause();
    issue_command(ipg_pkg::OP_START, 5'd6);
    issue_command(ipg_pkg::OP_ADVANCE, 5'd0);
    wait_for_drain();
    issue_command(ipg_pkg::OP_ADVANCE, 5'd0);
  endtask

  task automatic test_random_sequences();
    int unsigned sent;
    int unsigned steps;
    int unsigned seq_no;
    logic [ipg_pkg::PART_W-1:0] tot;
    sent   = 0;
    seq_no = 0;
    while (sent < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: begin
          tot = ipg_pkg::PART_W'($urandom_range(0, 31));
        end
        1: begin
          tot = ipg_pkg::PART_W'($urandom_range(8, 16));
        end
        default: begin
          tot = ipg_pkg::PART_W'($urandom_range(1, 7));
        end
      endcase
      issue_command(ipg_pkg::OP_START, tot);
      sent++;
      steps = $urandom_range(0, 20);
      repeat (steps) begin
        if ($urandom_range(0, 24) == 0) begin
          issue_command(ipg_pkg::OP_START, ipg_pkg::PART_W'($urandom_range(0, 31)));
        end else begin
          issue_command(ipg_pkg::OP_ADVANCE, ipg_pkg::PART_W'($urandom_range(0, 31)));
        end
        sent++;
      end
      if (seq_no == 6) wait_for_drain();
      seq_no++;
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk_i) begin
    part_beat_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_parts.size() == 0) begin
        $display("%0t: unexpected beat part=%0d last=%0b exhausted=%0b",
                 $time, part_o, last_part_o, exhausted_o);
        mismatches++;
      end else begin
        want = expected_parts.pop_front();
        if (part_o !== want.part || last_part_o !== want.last_part ||
            exhausted_o !== want.exhausted) begin
          $display("%0t: expected part=%0d last=%0b exhausted=%0b, %s",
                   $time, want.part, want.last_part, want.exhausted,
                   $sformatf("got part=%0d last=%0b exhausted=%0b",
                             part_o, last_part_o, exhausted_o));
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("** integer_partition_generator: FAILED **");
      $finish;
    end
  end

  initial begin
    mismatches  = 0;
    cycle_count = 0;
    no_idle     = 1'b0;
    shadow_len  = 0;
    shadow_sum  = 0;
    shadow_live = 1'b0;
    for (int unsigned k = 0; k < ipg_pkg::MAX_TOTAL; k++) shadow_parts[k] = '0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    operation_i = 1'b0;
    total_i     = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_idle_advance();
    test_corner_totals();
    test_full_enumeration();
    test_drain_pause();
    test_random_sequences();

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** integer_partition_generator: PASSED **");
    end else begin
      $display("** integer_partition_generator: FAILED **");
    end
    $finish;
  end

endmodule
